### rtl/eptm_pkg.sv
// ----------------------------------------------------------------------------
// eptm_pkg
// Shared types and constants for the echo pulse trimmed-mean block.
// ----------------------------------------------------------------------------
package eptm_pkg;

  // Field widths
  localparam int unsigned TimeW     = 16;
  localparam int unsigned DeadbandW = 8;
  localparam int unsigned ScaleW    = 17;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned NumSlots  = 4;
  localparam int unsigned SlotW     = 2;
  localparam int unsigned ProdW     = TimeW + ScaleW;

  typedef logic [TimeW-1:0]     ticks_t;
  typedef logic [DeadbandW-1:0] deadband_t;
  typedef logic [ScaleW-1:0]    scale_t;
  typedef logic [SlotW-1:0]     slot_t;

  // Event codes on the mode field; code 3 is unused and ignored
  typedef enum logic [ModeW-1:0] {
    MODE_TRIGGER = 2'd0,
    MODE_RISE    = 2'd1,
    MODE_FALL    = 2'd2
  } mode_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_DEADBAND = 1'b0,
    CFG_SCALE    = 1'b1
  } cfg_index_t;

  // Register reset values (scale is 1.36 in unsigned Q16)
  localparam deadband_t DEADBAND_RST = 8'd5;
  localparam scale_t    SCALE_RST    = 17'd89129;

endpackage

### rtl/eptm_capture.sv
// ----------------------------------------------------------------------------
// eptm_capture
// Trigger/edge sequencer: arms on trigger, latches the rising-edge time and
// stores the wrapped pulse width on the falling edge into a four-slot store.
// ----------------------------------------------------------------------------
module eptm_capture (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [eptm_pkg::ModeW-1:0]    mode,
  input  eptm_pkg::ticks_t              capture_time,
  output eptm_pkg::ticks_t              store [eptm_pkg::NumSlots],
  output logic                          fill_done
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_HIGH  = 2'd2
  } phase_t;

  phase_t            phase;
  eptm_pkg::ticks_t  start_time;
  eptm_pkg::slot_t   sample_index;

  logic              is_rise;
  logic              is_fall;
  eptm_pkg::ticks_t  pulse_width;

  // Event decode; edges in the wrong phase fall through as no-ops
  assign is_rise     = take && (mode == eptm_pkg::MODE_RISE) && (phase == PH_ARMED);
  assign is_fall     = take && (mode == eptm_pkg::MODE_FALL) && (phase == PH_HIGH);
  assign pulse_width = capture_time - start_time;  // modular, handles timer wrap

  // Fourth width of a set completes the store
  assign fill_done = is_fall && (sample_index == eptm_pkg::slot_t'(eptm_pkg::NumSlots - 1));

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      start_time   <= '0;
      sample_index <= '0;
    end else if (take) begin
      if (mode == eptm_pkg::MODE_TRIGGER) begin
        phase <= PH_ARMED;
      end else if (is_rise) begin
        start_time <= capture_time;
        phase      <= PH_HIGH;
      end else if (is_fall) begin
        phase        <= PH_IDLE;
        sample_index <= sample_index + 1'b1;
      end
    end
  end

  // Width store, no reset: every slot is written before the first read
  always_ff @(posedge clk) begin
    if (is_fall) begin
      store[sample_index] <= pulse_width;
    end
  end

endmodule

### rtl/echo_pulse_trimmed_mean.sv
// ----------------------------------------------------------------------------
// echo_pulse_trimmed_mean
// Ultrasonic echo pulse-width averaging with scaled distance and report flag.
// ----------------------------------------------------------------------------
// Input events (trigger, rising edge, falling edge) are taken one per clock.
// Every fourth captured pulse width yields one result: the mean of the middle
// two widths, the distance (average * scale_q16 >> 16, saturated to 65535) and
// a report flag raised when the average moved more than the deadband away from
// the last reported value. After the falling edge that completes the set, a
// result passes the set-ready flag, then the trimmed-mean register, then the
// result register that also takes the distance product. Events that produce
// no result are absorbed in the cycle they are taken. The input stalls only
// while a finished set is held in the first stage because both later stages
// are full and the output is stalled.
// ----------------------------------------------------------------------------
module echo_pulse_trimmed_mean (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_wr,
  input  logic                              cfg_index,
  input  logic [eptm_pkg::CfgDataW-1:0]     cfg_data,
  // event channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [eptm_pkg::ModeW-1:0]        mode,
  input  logic [eptm_pkg::TimeW-1:0]        capture_time,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [eptm_pkg::TimeW-1:0]        average_ticks,
  output logic [eptm_pkg::TimeW-1:0]        distance,
  output logic                              report
);

  // Configuration registers
  eptm_pkg::deadband_t deadband;
  eptm_pkg::scale_t    scale_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband  <= eptm_pkg::DEADBAND_RST;
      scale_q16 <= eptm_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        eptm_pkg::CFG_DEADBAND: deadband  <= cfg_data[eptm_pkg::DeadbandW-1:0];
        eptm_pkg::CFG_SCALE:    scale_q16 <= cfg_data[eptm_pkg::ScaleW-1:0];
        default:                deadband  <= deadband;
      endcase
    end
  end

  // Pipeline control
  logic take;
  logic fire;
  logic fill_done;
  logic s2_valid;
  logic s2_load;
  logic out_load;

  assign out_load = s2_valid && (!out_valid || !out_stall);
  assign s2_load  = fire && (!s2_valid || out_load);
  assign in_stall = fire && !s2_load;
  assign take     = in_valid && !in_stall;

  // Stage 1: capture sequencer and width store
  eptm_pkg::ticks_t store [eptm_pkg::NumSlots];

  eptm_capture u_capture (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .mode         (mode),
    .capture_time (capture_time),
    .store        (store),
    .fill_done    (fill_done)
  );

  // Full set waiting for the mean stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fire <= 1'b0;
    end else if (s2_load) begin
      fire <= fill_done;
    end else if (fill_done) begin
      fire <= 1'b1;
    end
  end

  // Stage 2: trimmed mean (max and min both tie to the later slot)
  eptm_pkg::ticks_t vmax, vmin, mean_val;
  eptm_pkg::slot_t  imax, imin;
  logic [eptm_pkg::TimeW:0] mid_sum;

  always_comb begin
    vmax    = store[0];
    vmin    = store[0];
    imax    = '0;
    imin    = '0;
    mid_sum = '0;
    for (int i = 1; i < eptm_pkg::NumSlots; i++) begin
      if (store[i] >= vmax) begin
        vmax = store[i];
        imax = eptm_pkg::slot_t'(i);
      end
      if (store[i] <= vmin) begin
        vmin = store[i];
        imin = eptm_pkg::slot_t'(i);
      end
    end
    for (int i = 0; i < eptm_pkg::NumSlots; i++) begin
      if ((eptm_pkg::slot_t'(i) != imax) && (eptm_pkg::slot_t'(i) != imin)) begin
        mid_sum = mid_sum + {1'b0, store[i]};
      end
    end
    mean_val = (imax == imin) ? vmin : mid_sum[eptm_pkg::TimeW:1];
  end

  eptm_pkg::ticks_t s2_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (out_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_avg <= mean_val;
    end
  end

  // Stage 3: distance scaling, deadband check, result register
  logic [eptm_pkg::ProdW-1:0] product;
  eptm_pkg::ticks_t           dist_val;
  eptm_pkg::ticks_t           abs_diff;
  eptm_pkg::ticks_t           last_reported;
  logic                       report_next;

  assign product  = {{eptm_pkg::ScaleW{1'b0}}, s2_avg} *
                    {{eptm_pkg::TimeW{1'b0}}, scale_q16};
  // product >> 16 needs 17 bits; saturate when the top one is set
  assign dist_val = (|product[eptm_pkg::ProdW-1:2*eptm_pkg::TimeW]) ? '1
                  : product[2*eptm_pkg::TimeW-1:eptm_pkg::TimeW];
  assign abs_diff = (s2_avg > last_reported) ? (s2_avg - last_reported)
                                             : (last_reported - s2_avg);
  assign report_next = abs_diff > {{(eptm_pkg::TimeW-eptm_pkg::DeadbandW){1'b0}}, deadband};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_reported <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        if (report_next) begin
          last_reported <= s2_avg;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_ticks <= s2_avg;
      distance      <= dist_val;
      report        <= report_next;
    end
  end

endmodule
